>>> src/cem_pkg.sv
`timescale 1ns / 1ps

package cem_pkg;

	typedef logic [63:0] u64_t;
	typedef logic [31:0] u32_t;
	typedef logic [51:0] prod_t;

	localparam logic [19:0] US_PER_SEC = 20'd1000000;

	localparam logic [1:0] KIND_MAINTAIN    = 2'd0;
	localparam logic [1:0] KIND_READ_US     = 2'd1;
	localparam logic [1:0] KIND_READ_CYCLES = 2'd2;

	localparam logic [1:0] REG_SOURCE_MODE = 2'd0;
	localparam logic [1:0] REG_COUNT_FREQ  = 2'd1;
	localparam logic [1:0] REG_WRAP_PERIOD = 2'd2;

	localparam logic       MODE_EXTEND_32 = 1'b0;

	localparam u32_t FREQ_RESET = 32'd1000000;
	localparam u32_t WRAP_RESET = 32'd1000;

	localparam logic [62:0] TIME_ALL_ONES = '1;

endpackage

>>> src/cem_divider.sv
`timescale 1ns / 1ps

module cem_divider (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  cem_pkg::u64_t dividend,
	input  cem_pkg::u32_t divisor,
	output logic          done,
	output cem_pkg::u64_t quotient,
	output cem_pkg::u32_t remainder
);
	import cem_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	u64_t        quo_q;
	u32_t        rem_q;
	u32_t        div_q;
	logic [32:0] shifted;
	logic [32:0] diff;
	logic        ge;

	// One quotient bit per cycle; the partial remainder stays below the divisor.
	assign shifted = {rem_q, quo_q[63]};
	assign ge      = shifted >= {1'b0, div_q};
	assign diff    = shifted - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd63;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[62:0], ge};
			rem_q <= ge ? diff[31:0] : shifted[31:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

>>> src/cem_multiplier.sv
`timescale 1ns / 1ps

module cem_multiplier (
	input  logic           clk,
	input  cem_pkg::u32_t  operand,
	output cem_pkg::prod_t product
);
	import cem_pkg::*;

	prod_t product_s1;

	always_ff @(posedge clk) begin
		product_s1 <= operand * US_PER_SEC;
	end

	assign product = product_s1;

endmodule

>>> src/counter_extend_to_microseconds.sv
`timescale 1ns / 1ps

// Extends a sampled hardware counter to a 64-bit time base and reads it back in counter
// cycles or in microseconds. A maintain word gives no result. A cycle read passes
// through the extend state into a pending result, which is registered on the output
// once the output is free. For a microsecond read one divider that produces one
// quotient bit per cycle runs twice over 64 bits, once for the whole seconds and once
// for the fraction, with a 32 by 20 bit multiplier shared for the scaling between
// them. The block takes no new word while a read is in progress, but a finished result
// may wait on the output while the next word is taken.
module counter_extend_to_microseconds (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [63:0] counter_sample,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [62:0] time_value
);
	import cem_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EXT   = 3'd1;
	localparam logic [2:0] ST_DIV1  = 3'd2;
	localparam logic [2:0] ST_MUL_A = 3'd3;
	localparam logic [2:0] ST_MUL_B = 3'd4;
	localparam logic [2:0] ST_MUL_C = 3'd5;
	localparam logic [2:0] ST_MUL_D = 3'd6;
	localparam logic [2:0] ST_DIV2  = 3'd7;

	logic        source_mode_q;
	u32_t        count_freq_q;
	u32_t        wrap_period_q;
	u64_t        high_part_q;
	u32_t        last_sample_q;
	logic [2:0]  state_q;
	logic        pending_q;
	logic [1:0]  kind_q;
	u64_t        sample_q;
	u64_t        whole_q;
	logic [62:0] res_q;
	logic        out_valid_q;
	logic [62:0] time_value_q;

	logic        accept;
	logic        wrap;
	u64_t        ext_time;
	logic        div_start;
	u64_t        div_dividend;
	logic        div_done;
	u64_t        div_quo;
	u32_t        div_rem;
	u32_t        mul_operand;
	prod_t       mul_product;
	logic        out_free;
	u64_t        us_result;

	assign in_ready = (state_q == ST_IDLE) && !pending_q;
	assign accept   = in_valid && in_ready;
	assign wrap     = counter_sample[31:0] < last_sample_q;
	assign ext_time = (source_mode_q == MODE_EXTEND_32) ?
		high_part_q + {32'd0, last_sample_q} : sample_q;
	assign out_free = !out_valid_q || out_ready;
	assign us_result = whole_q + div_quo;

	assign div_start = ((state_q == ST_EXT) && (kind_q == KIND_READ_US) &&
		(count_freq_q != '0)) || (state_q == ST_MUL_D);
	assign div_dividend = (state_q == ST_EXT) ? ext_time : {12'd0, mul_product};

	always_comb begin
		unique case (state_q)
			ST_MUL_A: mul_operand = div_quo[31:0];
			ST_MUL_B: mul_operand = div_quo[63:32];
			default:  mul_operand = div_rem;
		endcase
	end

	cem_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (count_freq_q),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	cem_multiplier u_multiplier (
		.clk     (clk),
		.operand (mul_operand),
		.product (mul_product)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_mode_q <= 1'b0;
			count_freq_q  <= FREQ_RESET;
			wrap_period_q <= WRAP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SOURCE_MODE: source_mode_q <= cfg_data[0];
				REG_COUNT_FREQ:  count_freq_q  <= cfg_data;
				REG_WRAP_PERIOD: wrap_period_q <= cfg_data;
				default:         ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_part_q   <= '0;
			last_sample_q <= '0;
		end else if (accept && (source_mode_q == MODE_EXTEND_32)) begin
			if (wrap) begin
				high_part_q <= high_part_q + {32'd0, wrap_period_q};
			end
			last_sample_q <= counter_sample[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= kind;
			sample_q <= counter_sample;
		end
		if (state_q == ST_MUL_B) begin
			whole_q <= {12'd0, mul_product};
		end else if (state_q == ST_MUL_C) begin
			whole_q <= whole_q + {mul_product[31:0], 32'd0};
		end
		if (state_q == ST_EXT) begin
			if (kind_q == KIND_READ_CYCLES) begin
				res_q <= ext_time[62:0];
			end else begin
				res_q <= TIME_ALL_ONES;
			end
		end else if ((state_q == ST_DIV2) && div_done) begin
			res_q <= us_result[62:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pending_q <= 1'b0;
		end else begin
			if (pending_q && out_free) begin
				pending_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && ((kind == KIND_READ_US) || (kind == KIND_READ_CYCLES))) begin
						state_q <= ST_EXT;
					end
				end
				ST_EXT: begin
					if (div_start) begin
						state_q <= ST_DIV1;
					end else begin
						state_q   <= ST_IDLE;
						pending_q <= 1'b1;
					end
				end
				ST_DIV1: begin
					if (div_done) begin
						state_q <= ST_MUL_A;
					end
				end
				ST_MUL_A: state_q <= ST_MUL_B;
				ST_MUL_B: state_q <= ST_MUL_C;
				ST_MUL_C: state_q <= ST_MUL_D;
				ST_MUL_D: state_q <= ST_DIV2;
				ST_DIV2: begin
					if (div_done) begin
						state_q   <= ST_IDLE;
						pending_q <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pending_q && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pending_q && out_free) begin
			time_value_q <= res_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign time_value = time_value_q;

endmodule
